// File: rtl/rc2bd_pkg.sv
// Shared types, constants and helpers for the RC2 block decrypt engine.
// Used by every module under rtl/ except rc2bd_ram. No dependencies.
`default_nettype none

package rc2bd_pkg;

    localparam int WORD_W    = 16;
    localparam int KEY_DEPTH = 64;
    localparam int KEY_AW    = 6;
    localparam int ROUND_W   = 4;
    localparam int ROUNDS    = 16;

    localparam logic [ROUND_W-1:0] ROUND_FIRST  = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] ROUND_LAST   = '0;
    localparam logic [ROUND_W-1:0] MASH_ROUND_A = ROUND_W'(10);
    localparam logic [ROUND_W-1:0] MASH_ROUND_B = ROUND_W'(4);

    localparam logic [1:0] WORD_R0 = 2'd0;
    localparam logic [1:0] WORD_R1 = 2'd1;
    localparam logic [1:0] WORD_R2 = 2'd2;
    localparam logic [1:0] WORD_R3 = 2'd3;

    // input beat opcodes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic              cmd;
        logic [KEY_AW-1:0] key_index;
        word_t             key_word;
        word_t             cipher_w0;
        word_t             cipher_w1;
        word_t             cipher_w2;
        word_t             cipher_w3;
        logic              final_block;
    } in_beat_t;

    typedef struct packed {
        word_t plain_w0;
        word_t plain_w1;
        word_t plain_w2;
        word_t plain_w3;
        logic  final_out;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic               key_wr;    // load beat: write key table
        logic               blk_load;  // decrypt beat: capture block
        logic               step;      // execute current sub-step
        logic               mash;      // current sub-step is a mash
        logic [1:0]         word;      // word updated by current sub-step
        logic               last;      // final sub-step of the block
        logic               rd_en;     // fetch key word for next sub-step
        logic               rd_mash;   // next sub-step is a mash
        logic [1:0]         rd_word;
        logic [ROUND_W-1:0] rd_round;
    } ctl_t;

    // inverse-round rotate right: R3 by 5, R2 by 3, R1 by 2, R0 by 1
    function automatic word_t rotr_word(input word_t v, input logic [1:0] w);
        word_t r;
        case (w)
            WORD_R3: r = {v[4:0], v[15:5]};
            WORD_R2: r = {v[2:0], v[15:3]};
            WORD_R1: r = {v[1:0], v[15:2]};
            default: r = {v[0], v[15:1]};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rc2bd_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module rc2bd_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/rc2bd_ctrl.sv
// Sequencer for RC2 decryption: walks 16 rounds of 4 sub-steps plus the
// two mash passes, and owns the handshakes. Depends on rc2bd_pkg.
`default_nettype none

module rc2bd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_cmd,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rc2bd_pkg::ctl_t    ctl
);

    typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

    state_t                             state_reg, state_next;
    logic [rc2bd_pkg::ROUND_W-1:0]      round_reg, round_next;
    logic [1:0]                         word_reg, word_next;
    logic                               mash_reg, mash_next;
    logic                               out_valid_reg, out_valid_next;

    logic [rc2bd_pkg::ROUND_W-1:0]      step_round;
    logic [1:0]                         step_word;
    logic                               step_mash;
    logic                               accept;
    logic                               last_step;
    logic                               advance;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign last_step = (state_reg == ST_RUN) && (round_reg == rc2bd_pkg::ROUND_LAST)
                       && (word_reg == rc2bd_pkg::WORD_R0) && !mash_reg;
    // a finished block waits in its last sub-step while the result slot is full
    assign advance   = (state_reg == ST_RUN) && !(last_step && out_valid_reg && !out_ready);

    // sub-step that follows the current one
    always_comb
    begin
        step_round = round_reg;
        step_word  = word_reg - 2'd1;
        step_mash  = mash_reg;
        if (word_reg == rc2bd_pkg::WORD_R0)
        begin
            step_word = rc2bd_pkg::WORD_R3;
            if (mash_reg)
            begin
                step_mash = 1'b0;
            end
            else
            begin
                step_round = round_reg - rc2bd_pkg::ROUND_W'(1);
                step_mash  = (step_round == rc2bd_pkg::MASH_ROUND_A)
                             || (step_round == rc2bd_pkg::MASH_ROUND_B);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        mash_next      = mash_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == rc2bd_pkg::CMD_DECRYPT))
                begin
                    state_next = ST_RUN;
                    round_next = rc2bd_pkg::ROUND_FIRST;
                    word_next  = rc2bd_pkg::WORD_R3;
                    mash_next  = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    if (last_step)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        round_next = step_round;
                        word_next  = step_word;
                        mash_next  = step_mash;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            word_reg      <= '0;
            mash_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            word_reg      <= word_next;
            mash_reg      <= mash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl.key_wr   = accept && (in_cmd == rc2bd_pkg::CMD_LOAD);
        ctl.blk_load = accept && (in_cmd == rc2bd_pkg::CMD_DECRYPT);
        ctl.step     = advance;
        ctl.mash     = mash_reg;
        ctl.word     = word_reg;
        ctl.last     = last_step;
        if (state_reg == ST_IDLE)
        begin
            // first sub-step is round 15, word R3
            ctl.rd_en    = ctl.blk_load;
            ctl.rd_mash  = 1'b0;
            ctl.rd_word  = rc2bd_pkg::WORD_R3;
            ctl.rd_round = rc2bd_pkg::ROUND_FIRST;
        end
        else
        begin
            ctl.rd_en    = advance && !last_step;
            ctl.rd_mash  = step_mash;
            ctl.rd_word  = step_word;
            ctl.rd_round = step_round;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rc2bd_datapath.sv
// Datapath for RC2 decryption: four working words, one sub-step unit,
// key table RAM and result register. Depends on rc2bd_pkg and rc2bd_ram.
`default_nettype none

module rc2bd_datapath (
    input  wire logic                clk,
    input  wire rc2bd_pkg::ctl_t     ctl,
    input  wire rc2bd_pkg::in_beat_t in_beat,
    output rc2bd_pkg::out_beat_t     out_beat
);

    rc2bd_pkg::word_t r0_reg, r1_reg, r2_reg, r3_reg;
    logic             final_reg;
    rc2bd_pkg::out_beat_t out_reg;

    rc2bd_pkg::word_t key;
    logic [rc2bd_pkg::KEY_AW-1:0] rd_addr;

    // roles of the words around the one being updated
    rc2bd_pkg::word_t cur, nb1, prv1, prv2;
    rc2bd_pkg::word_t mix_f;
    rc2bd_pkg::word_t new_word;
    rc2bd_pkg::word_t mash_src;

    rc2bd_ram #(
        .DATA_W (rc2bd_pkg::WORD_W),
        .DEPTH  (rc2bd_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ctl.key_wr),
        .wr_addr (in_beat.key_index),
        .wr_data (in_beat.key_word),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (key)
    );

    // mash of word w reads the key at the low six bits of word w-1;
    // that word is already final when the address is issued
    always_comb
    begin
        case (ctl.rd_word)
            rc2bd_pkg::WORD_R3: mash_src = r2_reg;
            rc2bd_pkg::WORD_R2: mash_src = r1_reg;
            rc2bd_pkg::WORD_R1: mash_src = r0_reg;
            default:            mash_src = r3_reg;
        endcase
        if (ctl.rd_mash)
        begin
            rd_addr = mash_src[rc2bd_pkg::KEY_AW-1:0];
        end
        else
        begin
            rd_addr = {ctl.rd_round, ctl.rd_word};
        end
    end

    always_comb
    begin
        case (ctl.word)
            rc2bd_pkg::WORD_R3:
            begin
                cur = r3_reg; nb1 = r0_reg; prv1 = r2_reg; prv2 = r1_reg;
            end
            rc2bd_pkg::WORD_R2:
            begin
                cur = r2_reg; nb1 = r3_reg; prv1 = r1_reg; prv2 = r0_reg;
            end
            rc2bd_pkg::WORD_R1:
            begin
                cur = r1_reg; nb1 = r2_reg; prv1 = r0_reg; prv2 = r3_reg;
            end
            default:
            begin
                cur = r0_reg; nb1 = r1_reg; prv1 = r3_reg; prv2 = r2_reg;
            end
        endcase

        mix_f = (nb1 & ~prv1) + (prv2 & prv1) + key;
        if (ctl.mash)
        begin
            new_word = cur - key;
        end
        else
        begin
            new_word = rc2bd_pkg::rotr_word(cur, ctl.word) - mix_f;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.blk_load)
        begin
            r0_reg    <= in_beat.cipher_w0;
            r1_reg    <= in_beat.cipher_w1;
            r2_reg    <= in_beat.cipher_w2;
            r3_reg    <= in_beat.cipher_w3;
            final_reg <= in_beat.final_block;
        end
        else if (ctl.step && ctl.last)
        begin
            out_reg.plain_w0  <= new_word;
            out_reg.plain_w1  <= r1_reg;
            out_reg.plain_w2  <= r2_reg;
            out_reg.plain_w3  <= r3_reg;
            out_reg.final_out <= final_reg;
        end
        else if (ctl.step)
        begin
            case (ctl.word)
                rc2bd_pkg::WORD_R3: r3_reg <= new_word;
                rc2bd_pkg::WORD_R2: r2_reg <= new_word;
                rc2bd_pkg::WORD_R1: r1_reg <= new_word;
                default:            r0_reg <= new_word;
            endcase
        end
    end

    assign out_beat = out_reg;

endmodule

`default_nettype wire

// File: rtl/rc2_block_decrypt.sv
// RC2 64-bit block decryption engine (ECB), top level.
// Depends on rc2bd_pkg, rc2bd_ctrl, rc2bd_datapath (with rc2bd_ram).
//
//  channel   signals                        content of one beat
//  -------   ----------------------------   -----------------------------------------
//  input     in_valid / in_ready / in_beat  key table write or one ciphertext block
//  output    out_valid / out_ready / out_beat  four plaintext words and final mark
//
// A decrypt beat runs one key prefetch, then 72 sub-steps (64 mixing, 8 mash),
// one key word read per cycle from the single read port of the key table.
// Input is accepted only between blocks; a result waiting in the output
// register does not block the next block, which holds in its last sub-step
// only if the previous result is still untaken. Reset clears control state;
// the key table is undefined until loaded.
`default_nettype none

module rc2_block_decrypt (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rc2bd_pkg::in_beat_t  in_beat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rc2bd_pkg::out_beat_t      out_beat
);

    rc2bd_pkg::ctl_t ctl;

    rc2bd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_beat.cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    rc2bd_datapath u_datapath (
        .clk      (clk),
        .ctl      (ctl),
        .in_beat  (in_beat),
        .out_beat (out_beat)
    );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for rc2_block_decrypt: key loads and ECB decrypt beats.
// Needs rc2bd_pkg and the RTL under rtl/; a behavioral RC2 inverse model below
// supplies expected plaintext for each decrypt beat whose row gives no expected result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rc2bd_pkg::*;

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_beat;

    word_t     key_shadow [KEY_DEPTH];
    out_beat_t plain_queue [$];
    stim_row_t dir_rows [$];
    int        err_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    rc2_block_decrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sixteen inverse rounds, 15 down to 0, mash before rounds 10 and 4
    function automatic out_beat_t rc2_unmix(input in_beat_t b);
        word_t     r0, r1, r2, r3;
        int        k;
        out_beat_t o;
        r0 = b.cipher_w0;
        r1 = b.cipher_w1;
        r2 = b.cipher_w2;
        r3 = b.cipher_w3;
        for (int rnd = ROUNDS - 1; rnd >= 0; rnd--)
        begin
            k = rnd * 4;
            if (rnd == int'(MASH_ROUND_A) || rnd == int'(MASH_ROUND_B))
            begin
                r3 = r3 - key_shadow[r2[5:0]];
                r2 = r2 - key_shadow[r1[5:0]];
                r1 = r1 - key_shadow[r0[5:0]];
                r0 = r0 - key_shadow[r3[5:0]];
            end
            r3 = {r3[4:0], r3[15:5]};
            r3 = r3 - ((r0 & ~r2) + (r1 & r2) + key_shadow[k + 3]);
            r2 = {r2[2:0], r2[15:3]};
            r2 = r2 - ((r3 & ~r1) + (r0 & r1) + key_shadow[k + 2]);
            r1 = {r1[1:0], r1[15:2]};
            r1 = r1 - ((r2 & ~r0) + (r3 & r0) + key_shadow[k + 1]);
            r0 = {r0[0], r0[15:1]};
            r0 = r0 - ((r1 & ~r3) + (r2 & r3) + key_shadow[k]);
        end
        o.plain_w0  = r0;
        o.plain_w1  = r1;
        o.plain_w2  = r2;
        o.plain_w3  = r3;
        o.final_out = b.final_block;
        return o;
    endfunction

    function automatic word_t pick_word();
        word_t w;
        case ($urandom_range(0, 15))
            0:       w = '0;
            1:       w = '1;
            default: w = word_t'($urandom_range(0, 65535));
        endcase
        return w;
    endfunction

    // cipher fields and final mark carry junk; the block must ignore them
    function automatic in_beat_t mk_load(input int idx, input word_t kw, input word_t junk);
        in_beat_t b;
        b.cmd         = CMD_LOAD;
        b.key_index   = KEY_AW'(idx);
        b.key_word    = kw;
        b.cipher_w0   = junk;
        b.cipher_w1   = ~junk;
        b.cipher_w2   = junk;
        b.cipher_w3   = ~junk;
        b.final_block = junk[0];
        return b;
    endfunction

    function automatic in_beat_t mk_dec(input word_t w0, input word_t w1, input word_t w2,
                                        input word_t w3, input logic fin, input int junk_idx,
                                        input word_t junk_kw);
        in_beat_t b;
        b.cmd         = CMD_DECRYPT;
        b.key_index   = KEY_AW'(junk_idx);
        b.key_word    = junk_kw;
        b.cipher_w0   = w0;
        b.cipher_w1   = w1;
        b.cipher_w2   = w2;
        b.cipher_w3   = w3;
        b.final_block = fin;
        return b;
    endfunction

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        b.cmd         = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_DECRYPT;
        b.key_index   = KEY_AW'($urandom_range(0, KEY_DEPTH - 1));
        b.key_word    = pick_word();
        b.cipher_w0   = pick_word();
        b.cipher_w1   = pick_word();
        b.cipher_w2   = pick_word();
        b.cipher_w3   = pick_word();
        b.final_block = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic stim_row_t row(input in_beat_t b, input bit typed, input out_beat_t w);
        stim_row_t r;
        r.beat  = b;
        r.typed = typed;
        r.want  = w;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] %s: got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // drive one beat, hold until taken, then book its effect
    task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (b.cmd == CMD_LOAD)
            key_shadow[b.key_index] = b.key_word;
        else
            plain_queue.push_back(typed ? want : rc2_unmix(b));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : out_check
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (plain_queue.size() == 0)
                report_mismatch("result beat with nothing pending", out_beat.plain_w0, '0);
            else
            begin
                want = plain_queue.pop_front();
                if (out_beat.plain_w0 !== want.plain_w0)
                    report_mismatch("plain_w0", out_beat.plain_w0, want.plain_w0);
                if (out_beat.plain_w1 !== want.plain_w1)
                    report_mismatch("plain_w1", out_beat.plain_w1, want.plain_w1);
                if (out_beat.plain_w2 !== want.plain_w2)
                    report_mismatch("plain_w2", out_beat.plain_w2, want.plain_w2);
                if (out_beat.plain_w3 !== want.plain_w3)
                    report_mismatch("plain_w3", out_beat.plain_w3, want.plain_w3);
                if (out_beat.final_out !== want.final_out)
                    report_mismatch("final_out", 16'(out_beat.final_out), 16'(want.final_out));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : main
        int        idle_pct [4];
        int        stall_pct [4];
        out_beat_t zero_fin;
        out_beat_t none;
        idle_pct  = '{0, 75, 0, 27};
        stall_pct = '{0, 0, 75, 27};
        none      = '0;
        zero_fin  = '0;
        zero_fin.final_out = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry is read by each block, so fill the whole table with zeros first
        for (int i = 0; i < KEY_DEPTH; i++)
            send_beat(mk_load(i, '0, pick_word()), 1'b0, none);

        // all-zero keys: a zero block decrypts to zero
        dir_rows.push_back(row(mk_dec('0, '0, '0, '0, 1'b0, 0, '0), 1'b1, none));
        dir_rows.push_back(row(mk_dec('0, '0, '0, '0, 1'b1, 63, '1), 1'b1, zero_fin));
        dir_rows.push_back(row(mk_dec('1, '1, '1, '1, 1'b0, 0, '0), 1'b0, none));
        dir_rows.push_back(row(mk_load(0, '1, '1), 1'b0, none));
        dir_rows.push_back(row(mk_load(63, '1, '0), 1'b0, none));
        dir_rows.push_back(row(mk_load(31, 16'h8001, 16'h5A5A), 1'b0, none));
        dir_rows.push_back(row(mk_dec('0, '0, '0, '0, 1'b0, 0, '0), 1'b0, none));
        dir_rows.push_back(row(mk_dec('1, '1, '1, '1, 1'b1, 63, '1), 1'b0, none));
        dir_rows.push_back(row(mk_dec(16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 1'b0, 17, 16'h1111),
                               1'b0, none));
        // low six bits of every cipher word set
        dir_rows.push_back(row(mk_dec(16'h003F, 16'h003F, 16'h003F, 16'h003F, 1'b1, 0, '0),
                               1'b0, none));
        dir_rows.push_back(row(mk_load(0, '0, '1), 1'b0, none));
        dir_rows.push_back(row(mk_load(63, '0, '1), 1'b0, none));
        dir_rows.push_back(row(mk_load(31, '0, '0), 1'b0, none));
        dir_rows.push_back(row(mk_dec('0, '0, '0, '0, 1'b0, 5, 16'hBEEF), 1'b1, none));
        dir_rows.push_back(row(mk_load(62, 16'h1234, 16'hC3C3), 1'b0, none));
        dir_rows.push_back(row(mk_dec('1, '0, '1, '0, 1'b0, 62, '0), 1'b0, none));
        dir_rows.push_back(row(mk_dec('0, '1, '0, '1, 1'b1, 1, '1), 1'b0, none));
        dir_rows.push_back(row(mk_dec(16'hFFC0, 16'h7FFF, 16'h0040, 16'hFFFE, 1'b0, 9, 16'h0F0F),
                               1'b0, none));
        dir_rows.push_back(row(mk_dec(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1, 2, '0),
                               1'b0, none));

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            for (int n = 0; n < 488; n++)
                send_beat(rand_beat(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (plain_queue.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
